// ===== sv/nearest_palette_color_search_macros.svh =====
// ----------------------------------------------------------------------------
// nearest_palette_color_search_macros.svh
// Assertion macros shared by the checker of the palette search block.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define NPCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("palette search check failed");

// Next-cycle implication, off while reset is high.
`define NPCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("palette search check failed");

`endif

// ===== sv/npcs_pkg.sv =====
// ----------------------------------------------------------------------------
// npcs_pkg
// Types and constants of the nearest palette colour search block.
// ----------------------------------------------------------------------------
`default_nettype none

package npcs_pkg;

   // command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam int COUNT_W = 9;   // palette_count register
   localparam int PROD_W  = 26;  // coefficient times 8-bit component
   localparam int SUM_W   = 27;  // three products plus rounding half
   localparam int FRAC_W  = 16;  // coefficient scale 2^16
   localparam int SQ_W    = 17;  // square of a difference up to 256
   localparam int DIST_W  = 19;  // sum of three squares

   localparam logic signed [SUM_W-1:0] HALF_SUM   = 27'sd32768;
   localparam logic signed [SUM_W-1:0] TRUNC_BIAS = 27'sd65535;
   localparam logic [8:0]              CHROMA_OFF = 9'd128;

   // rows: Y, U, V; columns: red, green, blue
   localparam logic signed [PROD_W-1:0] COEF [3][3] = '{
      '{ 26'sd19595,  26'sd38470,  26'sd7471 },
      '{-26'sd11056, -26'sd21712,  26'sd32768},
      '{ 26'sd32768, -26'sd27440, -26'sd5328 }
   };

   // one stored palette entry, V in the top bits
   typedef struct packed {
      logic [8:0] v;
      logic [8:0] u;
      logic [7:0] y;
   } npcs_yuv_type;

   // marks travelling with each palette read
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } npcs_tag_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_MUL,
      ST_LOAD_WRITE,
      ST_SCAN,
      ST_DRAIN
   } npcs_state_type;

endpackage

`default_nettype wire

// ===== sv/npcs_convert.sv =====
// ----------------------------------------------------------------------------
// npcs_convert
// RGB to YUV converter: registered coefficient products, then rounding sums.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_convert (
   input  wire logic                  clock,
   input  wire logic                  load_en,
   input  wire logic [7:0]            red,
   input  wire logic [7:0]            green,
   input  wire logic [7:0]            blue,
   output npcs_pkg::npcs_yuv_type     entry
);
   import npcs_pkg::*;

   logic signed [PROD_W-1:0] rgb_ext [3];
   logic signed [PROD_W-1:0] prod_in [3][3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [SUM_W-1:0]  sum     [3];
   logic signed [SUM_W-1:0]  quot    [3];

   assign rgb_ext[0] = $signed({{(PROD_W-8){1'b0}}, red});
   assign rgb_ext[1] = $signed({{(PROD_W-8){1'b0}}, green});
   assign rgb_ext[2] = $signed({{(PROD_W-8){1'b0}}, blue});

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = COEF[r][c] * rgb_ext[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         prod_ff <= prod_in;
      end
   end

   // add one half, then divide by 2^16 truncating toward zero
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum[r] = SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                + SUM_W'(prod_ff[r][2]) + HALF_SUM;
         if (sum[r] < 0) begin
            quot[r] = (sum[r] + TRUNC_BIAS) >>> FRAC_W;
         end else begin
            quot[r] = sum[r] >>> FRAC_W;
         end
      end
   end

   assign entry.y = quot[0][7:0];
   assign entry.u = quot[1][8:0] + CHROMA_OFF;
   assign entry.v = quot[2][8:0] + CHROMA_OFF;

endmodule

`default_nettype wire

// ===== sv/npcs_palette_ram.sv =====
// ----------------------------------------------------------------------------
// npcs_palette_ram
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_palette_ram #(
   parameter int DEPTH = 256,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [IDX_W-1:0]      wr_addr,
   input  wire npcs_pkg::npcs_yuv_type wr_data,
   input  wire logic [IDX_W-1:0]      rd_addr,
   output npcs_pkg::npcs_yuv_type     rd_data
);
   import npcs_pkg::*;

   npcs_yuv_type mem_ff [DEPTH];
   npcs_yuv_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/npcs_search.sv =====
// ----------------------------------------------------------------------------
// npcs_search
// Distance pipeline: squared differences, then sum and running minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module npcs_search #(
   parameter int IDX_W = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire npcs_pkg::npcs_tag_type tag,
   input  wire logic [IDX_W-1:0]      idx,
   input  wire npcs_pkg::npcs_yuv_type entry,
   input  wire logic [7:0]            query_y,
   input  wire logic [7:0]            query_u,
   input  wire logic [7:0]            query_v,
   output logic                       done,
   output logic [IDX_W-1:0]           best_idx
);
   import npcs_pkg::*;

   function automatic logic [8:0] abs_diff(input logic [8:0] a, input logic [8:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [8:0]        d_y, d_u, d_v;
   logic [SQ_W-1:0]   sq_y_in, sq_u_in, sq_v_in;
   logic [SQ_W-1:0]   sq_y_ff, sq_u_ff, sq_v_ff;
   npcs_tag_type      tag_a_ff;
   logic [IDX_W-1:0]  idx_a_ff;
   logic [DIST_W-1:0] dist_sum;
   logic [DIST_W-1:0] best_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic              done_ff;

   assign d_y = abs_diff({1'b0, query_y}, {1'b0, entry.y});
   assign d_u = abs_diff({1'b0, query_u}, entry.u);
   assign d_v = abs_diff({1'b0, query_v}, entry.v);

   assign sq_y_in = SQ_W'(d_y) * SQ_W'(d_y);
   assign sq_u_in = SQ_W'(d_u) * SQ_W'(d_u);
   assign sq_v_in = SQ_W'(d_v) * SQ_W'(d_v);

   assign dist_sum = DIST_W'(sq_y_ff) + DIST_W'(sq_u_ff) + DIST_W'(sq_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         tag_a_ff <= tag;
         done_ff  <= tag_a_ff.vld & tag_a_ff.last;
      end
   end

   // strict less keeps the lowest index on a tie
   always_ff @(posedge clock) begin
      sq_y_ff  <= sq_y_in;
      sq_u_ff  <= sq_u_in;
      sq_v_ff  <= sq_v_in;
      idx_a_ff <= idx;
      if (tag_a_ff.vld && (tag_a_ff.first || dist_sum < best_ff)) begin
         best_ff     <= dist_sum;
         best_idx_ff <= idx_a_ff;
      end
   end

   assign done     = done_ff;
   assign best_idx = best_idx_ff;

endmodule

`default_nettype wire

// ===== sv/nearest_palette_color_search.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Loads RGB palette entries as YUV and finds the nearest entry to a query.
// ----------------------------------------------------------------------------
//
//   channel   ports                        transfer
//   request   start, busy, req_*           start high while busy low
//   result    rsp_strobe, rsp_nearest_*    every cycle rsp_strobe is high
//   config    csr_wr_en, csr_wr_data       every cycle csr_wr_en is high
//
// A load holds busy after its transfer through ST_LOAD_MUL, for the
// coefficient products, and ST_LOAD_WRITE, for the rounding sums before the
// memory write. A query walks the palette memory one entry per cycle through
// its single read port; busy stays high until the search result is out,
// and rsp_strobe comes in the last cycle of busy.
// Reset is synchronous; it returns palette_count to 1 and the controller to
// idle. Palette contents stay undefined until loaded. The receiver takes
// every result, so nothing upstream of the result strobe ever stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_search #(
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic [7:0]  req_load_red,
   input  wire logic [7:0]  req_load_green,
   input  wire logic [7:0]  req_load_blue,
   input  wire logic [7:0]  req_query_luma,
   input  wire logic [7:0]  req_query_blue_diff,
   input  wire logic [7:0]  req_query_red_diff,
   // result
   output logic             rsp_strobe,
   output logic [7:0]       rsp_nearest_index,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [8:0]  csr_wr_data
);
   import npcs_pkg::*;

   localparam int IDX_W = $clog2(PALETTE_DEPTH);
   localparam logic [COUNT_W-1:0] DEPTH_CNT  = COUNT_W'(PALETTE_DEPTH);
   localparam logic [COUNT_W-1:0] DEPTH_LAST = COUNT_W'(PALETTE_DEPTH - 1);

   npcs_state_type     state_ff, state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] last_in;
   logic [IDX_W-1:0]   last_addr_ff;
   logic [IDX_W-1:0]   load_addr_ff;
   logic               load_ok_ff;
   logic [7:0]         query_y_ff, query_u_ff, query_v_ff;
   logic [IDX_W-1:0]   rd_addr_ff;
   npcs_tag_type       rd_tag_ff;
   logic [IDX_W-1:0]   rd_idx_ff;

   logic               accept;
   logic               ram_wr_en;
   logic               scan_issue;
   logic               scan_last;
   npcs_yuv_type       conv_entry;
   npcs_yuv_type       rd_entry;
   logic               search_done;
   logic [IDX_W-1:0]   best_idx;

   assign accept    = start & ~busy;
   assign scan_last = (rd_addr_ff == last_addr_ff);

   // clamp the count: zero searches entry 0, above depth searches all
   always_comb begin
      if (count_ff == '0) begin
         last_in = '0;
      end else if (count_ff > DEPTH_CNT) begin
         last_in = DEPTH_LAST;
      end else begin
         last_in = count_ff - COUNT_W'(1);
      end
   end

   // ---- controller ---------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_command == CMD_LOAD) ? ST_LOAD_MUL : ST_SCAN;
            end
         end
         ST_LOAD_MUL:   state_in = ST_LOAD_WRITE;
         ST_LOAD_WRITE: state_in = ST_IDLE;
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (search_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      ram_wr_en  = 1'b0;
      scan_issue = 1'b0;
      unique case (state_ff)
         ST_IDLE:       busy = 1'b0;
         ST_LOAD_MUL:   ;
         ST_LOAD_WRITE: ram_wr_en = load_ok_ff;
         ST_SCAN:       scan_issue = 1'b1;
         ST_DRAIN:      ;
         default:       ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= COUNT_W'(1);
         rd_tag_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         rd_tag_ff.vld   <= scan_issue;
         rd_tag_ff.first <= (rd_addr_ff == '0);
         rd_tag_ff.last  <= scan_last;
      end
   end

   // hold the request fields for the length of the item
   always_ff @(posedge clock) begin
      if (accept) begin
         load_addr_ff <= req_entry_index[IDX_W-1:0];
         load_ok_ff   <= ({1'b0, req_entry_index} < DEPTH_CNT);
         query_y_ff   <= req_query_luma;
         query_u_ff   <= req_query_blue_diff;
         query_v_ff   <= req_query_red_diff;
         last_addr_ff <= last_in[IDX_W-1:0];
      end
      // advance the read address while scanning, rewind when idle
      if (state_ff == ST_IDLE) begin
         rd_addr_ff <= '0;
      end else if (scan_issue) begin
         rd_addr_ff <= rd_addr_ff + IDX_W'(1);
      end
      rd_idx_ff <= rd_addr_ff;
   end

   // ---- datapath -----------------------------------------------------------
   npcs_convert u_convert (
      .clock   (clock),
      .load_en (accept),
      .red     (req_load_red),
      .green   (req_load_green),
      .blue    (req_load_blue),
      .entry   (conv_entry)
   );

   npcs_palette_ram #(
      .DEPTH (PALETTE_DEPTH),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (load_addr_ff),
      .wr_data (conv_entry),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_entry)
   );

   npcs_search #(
      .IDX_W (IDX_W)
   ) u_search (
      .clock    (clock),
      .reset    (reset),
      .tag      (rd_tag_ff),
      .idx      (rd_idx_ff),
      .entry    (rd_entry),
      .query_y  (query_y_ff),
      .query_u  (query_u_ff),
      .query_v  (query_v_ff),
      .done     (search_done),
      .best_idx (best_idx)
   );

   // the winning index holds steady through the strobe cycle
   assign rsp_strobe        = search_done;
   assign rsp_nearest_index = 8'(best_idx);

endmodule

`default_nettype wire

// ===== sv/npcs_checker.sv =====
// ----------------------------------------------------------------------------
// npcs_checker
// Port-level timing checks of the palette search block, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_palette_color_search_macros.svh"

module npcs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_command,
   input wire logic rsp_strobe
);
   import npcs_pkg::*;

   logic load_xfer;
   logic query_xfer;

   assign load_xfer  = start && !busy && (req_command == CMD_LOAD);
   assign query_xfer = start && !busy && (req_command == CMD_QUERY);

   `NPCS_ASSERT_NOW(a_strobe_in_busy, clock, reset, rsp_strobe, busy)
   `NPCS_ASSERT_NEXT(a_strobe_ends_item, clock, reset, rsp_strobe, !busy && !rsp_strobe)
   `NPCS_ASSERT_NEXT(a_load_timing, clock, reset, load_xfer, busy && !rsp_strobe ##1 busy && !rsp_strobe ##1 !busy && !rsp_strobe)
   `NPCS_ASSERT_NEXT(a_query_min_latency, clock, reset, query_xfer, busy && !rsp_strobe ##1 busy && !rsp_strobe ##1 busy && !rsp_strobe)

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_strobe  (rsp_strobe)
);

`default_nettype wire
